// ===== design/phr_pkg.sv =====
// Shared types and constants for the per-channel history ring.
// Depends on nothing; every other file of the block imports it.
package phr_pkg;

    localparam int CHANNELS_DEF     = 8;
    localparam int RING_DEPTH_DEF   = 16;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Widest address, slot and count that the parameter ranges allow.
    localparam int ADDR_MAX_W = 8;
    localparam int SLOT_MAX_W = 4;
    localparam int CNT_MAX_W  = 5;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed {
        logic        operation;
        logic [3:0]  channel;
        logic [63:0] payload;
        logic [4:0]  max_count;
    } cmd_t;

    typedef struct packed {
        logic [63:0] message;
        logic [3:0]  position;
        logic [4:0]  returned;
        logic        empty_res;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        JOB_APPEND = 2'd0,
        JOB_READ   = 2'd1,
        JOB_EMPTY  = 2'd2
    } job_kind_t;

    // One classified item as it waits between front and back.
    typedef struct packed {
        job_kind_t              kind;
        logic [ADDR_MAX_W-1:0]  base;
        logic [SLOT_MAX_W-1:0]  slot;
        logic [CNT_MAX_W-1:0]   count;
        logic [63:0]            payload;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

endpackage

// ===== design/phr_front.sv =====
// Front end: accepts items, keeps the write pointers and fill counts, and
// turns each item into a job for the back end. Depends on phr_pkg.
module phr_front #(
    parameter int CHANNELS   = phr_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH = phr_pkg::RING_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  phr_pkg::cmd_t   cmd,
    input  phr_pkg::q_stat_t q_stat,
    output logic            push,
    output phr_pkg::job_t   job
);
    import phr_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    logic [SLOT_W-1:0] wp_reg   [CHANNELS];
    logic [CNT_W-1:0]  fill_reg [CHANNELS];

    logic              accept;
    logic              ch_ok;
    logic              is_read;
    logic [CH_W-1:0]   chi;
    logic [SLOT_W-1:0] wp;
    logic [CNT_W-1:0]  fill;
    logic [SLOT_W-1:0] wp_next;
    logic [CNT_W-1:0]  fill_next;
    logic [4:0]        n;
    logic [SLOT_W:0]   start_sum;
    logic [SLOT_W-1:0] start_slot;

    assign busy    = q_stat.full;
    assign accept  = start && !q_stat.full;
    assign ch_ok   = {1'b0, cmd.channel} < 5'(CHANNELS);
    assign is_read = (cmd.operation == OP_READ);
    assign chi     = cmd.channel[CH_W-1:0];
    assign wp      = ch_ok ? wp_reg[chi] : '0;
    assign fill    = ch_ok ? fill_reg[chi] : '0;

    assign wp_next   = (wp == SLOT_W'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
    assign fill_next = (fill == CNT_W'(RING_DEPTH)) ? fill : fill + 1'b1;

    assign n = (cmd.max_count < 5'(fill)) ? cmd.max_count : 5'(fill);

    // The oldest wanted entry sits n slots behind the write pointer.
    assign start_sum  = (SLOT_W+1)'(wp) + (SLOT_W+1)'(RING_DEPTH) - (SLOT_W+1)'(n);
    assign start_slot = (start_sum >= (SLOT_W+1)'(RING_DEPTH))
                      ? SLOT_W'(start_sum - (SLOT_W+1)'(RING_DEPTH))
                      : SLOT_W'(start_sum);

    always_comb
    begin
        job.payload = cmd.payload;
        job.base    = ADDR_MAX_W'(32'(chi) * RING_DEPTH);
        job.count   = n;
        if (!is_read)
        begin
            job.kind = JOB_APPEND;
            job.slot = SLOT_MAX_W'(wp);
        end
        else if (!ch_ok || n == 5'd0)
        begin
            job.kind = JOB_EMPTY;
            job.slot = '0;
        end
        else
        begin
            job.kind = JOB_READ;
            job.slot = SLOT_MAX_W'(start_slot);
        end
    end

    // An append to a channel that does not exist is dropped here.
    assign push = accept && (is_read || ch_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (accept && !is_read && ch_ok)
        begin
            wp_reg[chi]   <= wp_next;
            fill_reg[chi] <= fill_next;
        end
    end

endmodule

// ===== design/phr_queue.sv =====
// Two-entry job queue that decouples the front end from the back end.
// Depends on phr_pkg for the job and status types.
module phr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  phr_pkg::job_t    job_in,
    input  logic             pop,
    output phr_pkg::job_t    job_out,
    output phr_pkg::q_stat_t q_stat
);
    import phr_pkg::*;

    job_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign job_out         = ent_reg[rd_ptr_reg];
    assign q_stat.full     = (cnt_reg == 2'd2);
    assign q_stat.nonempty = (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/phr_back.sv =====
// Back end: holds the history memory, performs appends and streams read
// runs one entry per cycle. Depends on phr_pkg.
module phr_back #(
    parameter int CHANNELS     = phr_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH   = phr_pkg::RING_DEPTH_DEF,
    parameter int PAYLOAD_BITS = phr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  phr_pkg::job_t    job,
    input  phr_pkg::q_stat_t q_stat,
    output logic             pop,
    output logic             done,
    output phr_pkg::result_t result
);
    import phr_pkg::*;

    localparam int SLOTS  = CHANNELS * RING_DEPTH;
    localparam int ADDR_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = $clog2(RING_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [3:0]        pos_reg, pos_next;
    logic [4:0]        total_reg, total_next;

    logic [PAYLOAD_BITS-1:0] hist_mem [SLOTS];
    logic [PAYLOAD_BITS-1:0] rdata_reg;

    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] cur_slot;
    logic [SLOT_W-1:0] cur_slot_inc;
    logic [ADDR_W-1:0] cur_base;

    logic       iss_vld, iss_empty, iss_last;
    logic [3:0] iss_pos;
    logic [4:0] iss_ret;

    logic       out_vld_reg, out_empty_reg, out_last_reg;
    logic [3:0] out_pos_reg;
    logic [4:0] out_ret_reg;

    assign pop = (state_reg == ST_IDLE) && q_stat.nonempty;

    assign cur_slot     = (state_reg == ST_RUN) ? slot_reg : SLOT_W'(job.slot);
    assign cur_base     = (state_reg == ST_RUN) ? base_reg : ADDR_W'(job.base);
    assign cur_slot_inc = (cur_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : cur_slot + 1'b1;
    assign addr         = cur_base + ADDR_W'(cur_slot);

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        we         = 1'b0;
        re         = 1'b0;
        iss_vld    = 1'b0;
        iss_empty  = 1'b0;
        iss_last   = 1'b0;
        iss_pos    = '0;
        iss_ret    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    unique case (job.kind)
                        JOB_APPEND:
                        begin
                            we = 1'b1;
                        end
                        JOB_READ:
                        begin
                            re       = 1'b1;
                            iss_vld  = 1'b1;
                            iss_ret  = job.count;
                            iss_last = (job.count == 5'd1);
                            if (job.count != 5'd1)
                            begin
                                state_next = ST_RUN;
                                slot_next  = cur_slot_inc;
                                base_next  = cur_base;
                                pos_next   = 4'd1;
                                total_next = job.count;
                            end
                        end
                        default:
                        begin
                            iss_vld   = 1'b1;
                            iss_empty = 1'b1;
                            iss_last  = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                re       = 1'b1;
                iss_vld  = 1'b1;
                iss_pos  = pos_reg;
                iss_ret  = total_reg;
                iss_last = (5'(pos_reg) + 5'd1 == total_reg);
                slot_next = cur_slot_inc;
                pos_next  = pos_reg + 4'd1;
                if (iss_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[addr] <= job.payload[PAYLOAD_BITS-1:0];
        end
        if (re)
        begin
            rdata_reg <= hist_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        base_reg    <= base_next;
        pos_reg     <= pos_next;
        total_reg   <= total_next;
        out_pos_reg <= iss_pos;
        out_ret_reg <= iss_ret;
        out_last_reg <= iss_last;
        out_empty_reg <= iss_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= iss_vld;
        end
    end

    assign done             = out_vld_reg;
    assign result.message   = out_empty_reg ? 64'd0 : 64'(rdata_reg);
    assign result.position  = out_pos_reg;
    assign result.returned  = out_ret_reg;
    assign result.empty_res = out_empty_reg;
    assign result.last      = out_last_reg;

    // A read run comes out without gaps, counting up with a steady length.
    a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_last_reg) |=> out_vld_reg)
        else $error("read run has a gap");

    a_run_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_last_reg) |=>
            (out_pos_reg == 4'($past(out_pos_reg) + 4'd1)))
        else $error("position does not advance by one");

    a_run_len_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_last_reg) |=> (out_ret_reg == $past(out_ret_reg)))
        else $error("run length changes within a run");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_last_reg && !out_empty_reg) |->
            (5'(out_pos_reg) + 5'd1 == out_ret_reg))
        else $error("last flag not on the final entry");

endmodule

// ===== design/per_channel_history_ring_unit.sv =====
// Top level of the per-channel history ring: front end, job queue, back end.
// Depends on phr_pkg, phr_front, phr_queue and phr_back.
//
//   channel   handshake            payload        direction
//   command   start / busy         cmd (cmd_t)    in
//   result    done (strobe)        result         out
//
// An append occupies the back end for a single memory write; a read makes one
// memory read per entry returned, one per cycle, or one empty result if none
// is returned. At the earliest, an accepted item is written into the job queue,
// popped by the back end and registered in its output registers before its
// result is on the ports. The front end takes an item every cycle while the
// two-entry job queue has room; busy is the queue being full. Reset clears
// pointers and fill counts at once; the history memory is not cleared. The
// receiver cannot stall, so each result is shown for exactly one cycle.
module per_channel_history_ring_unit #(
    parameter int CHANNELS     = phr_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH   = phr_pkg::RING_DEPTH_DEF,
    parameter int PAYLOAD_BITS = phr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  phr_pkg::cmd_t    cmd,
    output logic             done,
    output phr_pkg::result_t result
);
    import phr_pkg::*;

    logic    push;
    logic    pop;
    job_t    job_in;
    job_t    job_head;
    q_stat_t q_stat;

    phr_front #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .q_stat (q_stat),
        .push   (push),
        .job    (job_in)
    );

    phr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_head),
        .q_stat  (q_stat)
    );

    phr_back #(
        .CHANNELS     (CHANNELS),
        .RING_DEPTH   (RING_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job_head),
        .q_stat (q_stat),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule
